@@ design/tre_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tre_pkg: shared types and constants of the textbook RSA engine
// Beat payloads, register indexes and the small-prime table used by key
// derivation.
// ----------------------------------------------------------------------------
package tre_pkg;

  typedef struct packed {
    logic        opcode;
    logic [31:0] message;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic [31:0] public_exp;
    logic [31:0] private_exp;
    logic        status;
  } out_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 1'b1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // public exponent candidates never pass 63
  localparam int CW = 6;
  localparam logic [63:0] PRIME_MASK = 64'h28208A20A08A28AC;

  function automatic logic is_prime_small(input logic [CW-1:0] x);
    return PRIME_MASK[x];
  endfunction

endpackage
`default_nettype wire

@@ design/tre_modmul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tre_modmul: bit-serial modular multiplier
// Interleaved double-and-add, one multiplier bit per cycle, MSB first.
// Operands must be below the modulus.
// ----------------------------------------------------------------------------
module tre_modmul #(
  parameter int NW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] a_i,
  input  wire logic [NW-1:0] b_i,
  input  wire logic [NW-1:0] n_i,
  output logic               done_o,
  output logic [NW-1:0]      res_o
);

  localparam int CNTW = $clog2(NW);

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [NW-1:0]   a_r, a_nxt;
  logic [NW-1:0]   b_r, b_nxt;
  logic [NW-1:0]   r_r, r_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]     dbl, sum;
  logic [NW-1:0]   t1, t2;

  always_comb begin
    dbl = {r_r, 1'b0};
    t1  = (dbl >= {1'b0, n_i}) ? NW'(dbl - {1'b0, n_i}) : dbl[NW-1:0];
    sum = {1'b0, t1} + {1'b0, a_r};
    t2  = (sum >= {1'b0, n_i}) ? NW'(sum - {1'b0, n_i}) : sum[NW-1:0];
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    if (start_i) begin
      run_nxt = 1'b1;
      a_nxt   = a_i;
      b_nxt   = b_i;
      r_nxt   = '0;
      cnt_nxt = '0;
    end else if (run_r) begin
      r_nxt   = b_r[NW-1] ? t2 : t1;
      b_nxt   = {b_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NW-1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done_o = done_r;
  assign res_o  = r_r;

endmodule
`default_nettype wire

@@ design/tre_modexp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tre_modexp: modular exponentiation sequencer
// Reduces the base serially, then runs right-to-left square-and-multiply on
// the shared serial multiplier.
// ----------------------------------------------------------------------------
module tre_modexp #(
  parameter int NW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start_i,
  input  wire logic [31:0]   base_i,
  input  wire logic [NW-1:0] exp_i,
  input  wire logic [NW-1:0] n_i,
  output logic               busy_o,
  output logic [NW-1:0]      res_o
);

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_RED  = 5'b00010,
    E_CHK  = 5'b00100,
    E_MUL  = 5'b01000,
    E_SQR  = 5'b10000
  } exp_state_t;

  exp_state_t    state_r, state_nxt;
  logic [31:0]   msh_r, msh_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic [NW-1:0] ex_r, ex_nxt;
  logic [NW:0]   red;
  logic          mm_start, mm_done;
  logic [NW-1:0] mm_a, mm_res;

  tre_modmul #(.NW(NW)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (b_r),
    .n_i     (n_i),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    red       = {b_r, msh_r[31]};
    state_nxt = state_r;
    msh_nxt   = msh_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    ex_nxt    = ex_r;
    mm_start  = 1'b0;
    mm_a      = b_r;
    case (state_r)
      E_IDLE: begin
        if (start_i) begin
          msh_nxt   = base_i;
          ex_nxt    = exp_i;
          b_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = E_RED;
        end
      end
      E_RED: begin
        b_nxt   = (red >= {1'b0, n_i}) ? NW'(red - {1'b0, n_i}) : red[NW-1:0];
        msh_nxt = {msh_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          acc_nxt   = NW'(1);
          state_nxt = E_CHK;
        end
      end
      E_CHK: begin
        if (ex_r == '0) begin
          state_nxt = E_IDLE;
        end else if (ex_r[0]) begin
          mm_start  = 1'b1;
          mm_a      = acc_r;
          state_nxt = E_MUL;
        end else begin
          mm_start  = 1'b1;
          state_nxt = E_SQR;
        end
      end
      E_MUL: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          mm_start  = 1'b1;
          state_nxt = E_SQR;
        end
      end
      E_SQR: begin
        if (mm_done) begin
          b_nxt     = mm_res;
          ex_nxt    = {1'b0, ex_r[NW-1:1]};
          state_nxt = E_CHK;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    msh_r <= msh_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    ex_r  <= ex_nxt;
  end

  assign busy_o = (state_r != E_IDLE);
  assign res_o  = acc_r;

endmodule
`default_nettype wire

@@ design/tre_keygen.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tre_keygen: key derivation sequencer
// Serial products for n and phi, smallest small prime coprime to phi by
// serial remainder, then d = (k*phi + 1) / e by serial long division.
// ----------------------------------------------------------------------------
module tre_keygen #(
  parameter int RW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic [RW-1:0]     p_i,
  input  wire logic [RW-1:0]     q_i,
  output logic                   busy_o,
  output logic                   ok_o,
  output logic [2*RW-1:0]        n_o,
  output logic [tre_pkg::CW-1:0] e_o,
  output logic [2*RW-1:0]        d_o
);

  import tre_pkg::*;

  localparam int NW   = 2 * RW;
  localparam int NUMW = NW + CW;
  localparam int CNTW = $clog2(NUMW);

  typedef enum logic [6:0] {
    K_START = 7'b0000001,
    K_MUL   = 7'b0000010,
    K_CAND  = 7'b0000100,
    K_MOD   = 7'b0001000,
    K_TEST  = 7'b0010000,
    K_INV   = 7'b0100000,
    K_DIV   = 7'b1000000
  } key_state_t;

  key_state_t      state_r, state_nxt;
  logic            busy_r, busy_nxt;
  logic            ok_r, ok_nxt;
  logic [NW-1:0]   mp_r, mp_nxt, mpm_r, mpm_nxt;
  logic [RW-1:0]   mq_r, mq_nxt, mqm_r, mqm_nxt;
  logic [NW-1:0]   n_r, n_nxt, phi_r, phi_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   cand_r, cand_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   pm_r, pm_nxt;
  logic [CW-1:0]   v_r, v_nxt;
  logic [NUMW-1:0] sh_r, sh_nxt;
  logic [NUMW-1:0] num_r, num_nxt;
  logic [CW:0]     dtmp, vsum;
  logic            dge;
  logic [CW-1:0]   drem, vstep, rinc;

  always_comb begin
    dtmp  = {rem_r, sh_r[NUMW-1]};
    dge   = (dtmp >= {1'b0, cand_r});
    drem  = dge ? CW'(dtmp - {1'b0, cand_r}) : dtmp[CW-1:0];
    vsum  = {1'b0, v_r} + {1'b0, pm_r};
    vstep = (vsum >= {1'b0, cand_r}) ? CW'(vsum - {1'b0, cand_r}) : vsum[CW-1:0];
    rinc  = rem_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    ok_nxt    = ok_r;
    mp_nxt    = mp_r;
    mpm_nxt   = mpm_r;
    mq_nxt    = mq_r;
    mqm_nxt   = mqm_r;
    n_nxt     = n_r;
    phi_nxt   = phi_r;
    cnt_nxt   = cnt_r;
    cand_nxt  = cand_r;
    rem_nxt   = rem_r;
    pm_nxt    = pm_r;
    v_nxt     = v_r;
    sh_nxt    = sh_r;
    num_nxt   = num_r;
    if (start_i) begin
      state_nxt = K_START;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      case (state_r)
        K_START: begin
          if (p_i < RW'(2) || q_i < RW'(2)) begin
            ok_nxt   = 1'b0;
            busy_nxt = 1'b0;
          end else begin
            mp_nxt    = {{RW{1'b0}}, p_i};
            mpm_nxt   = {{RW{1'b0}}, RW'(p_i - 1'b1)};
            mq_nxt    = q_i;
            mqm_nxt   = RW'(q_i - 1'b1);
            n_nxt     = '0;
            phi_nxt   = '0;
            cnt_nxt   = '0;
            cand_nxt  = CW'(2);
            state_nxt = K_MUL;
          end
        end
        K_MUL: begin
          if (mq_r[0]) n_nxt = n_r + mp_r;
          if (mqm_r[0]) phi_nxt = phi_r + mpm_r;
          mp_nxt  = {mp_r[NW-2:0], 1'b0};
          mpm_nxt = {mpm_r[NW-2:0], 1'b0};
          mq_nxt  = {1'b0, mq_r[RW-1:1]};
          mqm_nxt = {1'b0, mqm_r[RW-1:1]};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNTW'(RW-1)) state_nxt = K_CAND;
        end
        K_CAND: begin
          if ({{(NW-CW){1'b0}}, cand_r} >= phi_r) begin
            ok_nxt   = 1'b0;
            busy_nxt = 1'b0;
          end else if (!is_prime_small(cand_r)) begin
            cand_nxt = cand_r + 1'b1;
          end else begin
            rem_nxt   = '0;
            sh_nxt    = {{CW{1'b0}}, phi_r};
            cnt_nxt   = '0;
            state_nxt = K_MOD;
          end
        end
        K_MOD: begin
          rem_nxt = drem;
          sh_nxt  = {sh_r[NUMW-2:0], dge};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNTW'(NUMW-1)) state_nxt = K_TEST;
        end
        K_TEST: begin
          if (rem_r != '0) begin
            pm_nxt    = rem_r;
            v_nxt     = (rinc == cand_r) ? '0 : rinc;
            num_nxt   = {{CW{1'b0}}, phi_r} + NUMW'(1);
            state_nxt = K_INV;
          end else begin
            cand_nxt  = cand_r + 1'b1;
            state_nxt = K_CAND;
          end
        end
        K_INV: begin
          if (v_r == '0) begin
            rem_nxt   = '0;
            sh_nxt    = num_r;
            cnt_nxt   = '0;
            state_nxt = K_DIV;
          end else begin
            v_nxt   = vstep;
            num_nxt = num_r + {{CW{1'b0}}, phi_r};
          end
        end
        K_DIV: begin
          rem_nxt = drem;
          sh_nxt  = {sh_r[NUMW-2:0], dge};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNTW'(NUMW-1)) begin
            ok_nxt   = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default: state_nxt = K_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= K_START;
      busy_r  <= 1'b1;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      ok_r    <= ok_nxt;
    end
    mp_r   <= mp_nxt;
    mpm_r  <= mpm_nxt;
    mq_r   <= mq_nxt;
    mqm_r  <= mqm_nxt;
    n_r    <= n_nxt;
    phi_r  <= phi_nxt;
    cnt_r  <= cnt_nxt;
    cand_r <= cand_nxt;
    rem_r  <= rem_nxt;
    pm_r   <= pm_nxt;
    v_r    <= v_nxt;
    sh_r   <= sh_nxt;
    num_r  <= num_nxt;
  end

  assign busy_o = busy_r;
  assign ok_o   = ok_r;
  assign n_o    = n_r;
  assign e_o    = cand_r;
  assign d_o    = sh_r[NW-1:0];

endmodule
`default_nettype wire

@@ design/textbook_rsa_engine_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// textbook_rsa_engine_unit: textbook RSA encrypt/decrypt engine
// Holds p and q, derives n, e and d, and raises each message to e or d mod n.
// ----------------------------------------------------------------------------
// One beat at a time. After reset or a write to either prime the key is
// derived again (RW is PRIME_BITS, at least 6); input beats are held off
// until it is done. The time of an item from accept to result beat is set
// by the bit-serial modular multiplier that serves every square and
// multiply. A key error answers without running the exponentiation.
// ----------------------------------------------------------------------------
module textbook_rsa_engine_unit #(
  parameter int PRIME_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PRIME_BITS-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tre_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tre_pkg::out_t                      out_data
);

  import tre_pkg::*;

  localparam int RW = (PRIME_BITS < 6) ? 6 : PRIME_BITS;
  localparam int NW = 2 * RW;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_RUN  = 2'b10
  } top_state_t;

  top_state_t    state_r, state_nxt;
  logic [RW-1:0] p_r, p_nxt, q_r, q_nxt;
  logic          err_r, err_nxt;
  logic          ov_r, ov_nxt;
  out_t          od_r, od_nxt;
  logic          kg_busy, kg_ok;
  logic [NW-1:0] kg_n, kg_d, mx_res, mx_exp;
  logic [CW-1:0] kg_e;
  logic          mx_busy, accept, mx_start;
  logic [NW+31:0] res_w, d_w;

  tre_keygen #(.RW(RW)) u_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cfg_we),
    .p_i     (p_r),
    .q_i     (q_r),
    .busy_o  (kg_busy),
    .ok_o    (kg_ok),
    .n_o     (kg_n),
    .e_o     (kg_e),
    .d_o     (kg_d)
  );

  tre_modexp #(.NW(NW)) u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mx_start),
    .base_i  (in_data.message),
    .exp_i   (mx_exp),
    .n_i     (kg_n),
    .busy_o  (mx_busy),
    .res_o   (mx_res)
  );

  assign in_stall = (state_r != T_IDLE) || kg_busy;
  assign accept   = in_valid && !in_stall;
  assign mx_start = accept && kg_ok;
  assign mx_exp   = (in_data.opcode == OP_DECRYPT) ? kg_d : {{(NW-CW){1'b0}}, kg_e};
  assign res_w    = {32'b0, mx_res};
  assign d_w      = {32'b0, kg_d};

  always_comb begin
    p_nxt     = p_r;
    q_nxt     = q_r;
    state_nxt = state_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PRIME_P: p_nxt = RW'(cfg_data);
        REG_PRIME_Q: q_nxt = RW'(cfg_data);
        default: ;
      endcase
    end
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          err_nxt   = !kg_ok;
          state_nxt = T_RUN;
        end
      end
      T_RUN: begin
        if (!mx_busy && (!ov_r || !out_stall)) begin
          ov_nxt = 1'b1;
          if (err_r) begin
            od_nxt = '{result: '0, public_exp: '0, private_exp: '0, status: 1'b1};
          end else begin
            od_nxt = '{result: res_w[31:0], public_exp: {{(32-CW){1'b0}}, kg_e},
                       private_exp: d_w[31:0], status: 1'b0};
          end
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      p_r     <= RW'(61);
      q_r     <= RW'(53);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      ov_r    <= ov_nxt;
    end
    err_r <= err_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

@@ design/tre_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tre_checker: port-level checks for the RSA engine
// Result beat rules and one-at-a-time behaviour seen at the ports.
// ----------------------------------------------------------------------------
module tre_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire tre_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.result == 32'd0 && out_data.public_exp == 32'd0 &&
      out_data.private_exp == 32'd0)
    else $error("error beat carries non-zero fields");

  a_ok_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.status |-> out_data.public_exp != 32'd0)
    else $error("good beat without public exponent");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

endmodule

bind textbook_rsa_engine_unit tre_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
